// File: hw/rtl/tqla_pkg.sv
`default_nettype none

package tqla_pkg;

    localparam int NUM_STATES      = 15;
    localparam int NUM_ACTIONS     = 5;
    localparam int TABLE_DEPTH     = NUM_STATES * NUM_ACTIONS;
    localparam int Q_WIDTH_DEFAULT = 16;

    localparam int POS_W      = 14;
    localparam int STATE_W    = 4;
    localparam int BAND_W     = 3;
    localparam int TREND_W    = 2;
    localparam int ACT_W      = 3;
    localparam int OP_W       = 2;
    localparam int ADDR_W     = 7;
    localparam int SUM_W      = 23;
    localparam int LEARN_W    = 16;
    localparam int OUT_Q_W    = 16;
    localparam int DISC_W     = 8;
    localparam int REWARD_W   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_BANDS  = 5;

    localparam logic [OP_W-1:0] OP_OBSERVE  = 2'd0;
    localparam logic [OP_W-1:0] OP_LEARN    = 2'd1;
    localparam logic [OP_W-1:0] OP_ACT      = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_EDGE_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_EDGE_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_EDGE_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_EDGE_FOUR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_EDGE_FIVE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEARN_STEPS = 3'd6;

    localparam logic [DISC_W-1:0]  DISCOUNT_RESET        = 8'd102;
    localparam logic [LEARN_W-1:0] MIN_LEARN_STEPS_RESET = 16'd500;
    localparam logic [POS_W-1:0]   BAND_EDGE_RESET [NUM_BANDS] =
        '{14'd1500, 14'd3000, 14'd4000, 14'd5500, 14'd7000};

    localparam logic [STATE_W-1:0] STATE_EXCEPTION = 4'd3;

    typedef logic [REWARD_W-1:0] reward_row_t [NUM_ACTIONS];

    localparam reward_row_t REWARD_ROM [NUM_STATES] = '{
        '{6'd0,  6'd0,  6'd0,  6'd4,  6'd0},
        '{6'd0,  6'd0,  6'd0,  6'd0,  6'd4},
        '{6'd0,  6'd0,  6'd0,  6'd0,  6'd4},
        '{6'd0,  6'd0,  6'd0,  6'd4,  6'd0},
        '{6'd0,  6'd0,  6'd0,  6'd4,  6'd0},
        '{6'd0,  6'd0,  6'd0,  6'd4,  6'd0},
        '{6'd0,  6'd0,  6'd15, 6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd40, 6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd15, 6'd0,  6'd0},
        '{6'd4,  6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd0,  6'd4,  6'd0,  6'd0,  6'd0},
        '{6'd0,  6'd4,  6'd0,  6'd0,  6'd0},
        '{6'd0,  6'd4,  6'd0,  6'd0,  6'd0},
        '{6'd4,  6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd4,  6'd0,  6'd0,  6'd0,  6'd0}
    };

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } qmem_port_t;

    function automatic logic [ADDR_W-1:0] q_addr(input logic [STATE_W-1:0] s,
                                                 input logic [ACT_W-1:0] a);
        return ADDR_W'({s, 2'b00}) + ADDR_W'(s) + ADDR_W'(a);
    endfunction

    // Four minus first index below four whose reward tops its row, else zero; zero becomes three in state three.
    function automatic logic [ACT_W-1:0] act_greedy(input logic [STATE_W-1:0] s);
        logic [ACT_W-1:0] idx;
        logic [ACT_W-1:0] chosen;
        logic             wins;
        logic             found;
        idx   = ACT_W'(NUM_ACTIONS - 1);
        found = 1'b0;
        for (int i = 0; i < NUM_ACTIONS - 1; i++)
        begin
            wins = 1'b1;
            for (int j = 0; j < NUM_ACTIONS; j++)
            begin
                if (j != i && !(REWARD_ROM[s][i] > REWARD_ROM[s][j]))
                begin
                    wins = 1'b0;
                end
            end
            if (wins && !found)
            begin
                idx   = ACT_W'(i);
                found = 1'b1;
            end
        end
        chosen = ACT_W'(NUM_ACTIONS - 1) - idx;
        if (chosen == '0 && s == STATE_EXCEPTION)
        begin
            chosen = ACT_W'(STATE_EXCEPTION);
        end
        return chosen;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tqla_qmem.sv
`default_nettype none

module tqla_qmem
    import tqla_pkg::*;
#(
    parameter int Q_WIDTH = Q_WIDTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire qmem_port_t         wr,
    input  wire logic [Q_WIDTH-1:0] wr_data,
    input  wire qmem_port_t         rd,
    output logic      [Q_WIDTH-1:0] rd_data
);

    logic [Q_WIDTH-1:0]     mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [Q_WIDTH-1:0]     rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr_data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    // An entry that was never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// File: hw/rtl/tabular_q_learning_agent.sv
// Tabular Q-learning agent for a line follower. Each input transfer carries a sensor
// position and an opcode; the position is quantized into one of 15 states from five
// programmable band edges and the trend against the previous non-reserved sample. Observe
// records the state, learn updates one entry of the 15 x 5 value table from the fixed
// reward and the discounted best value of the sample's row, and act returns the greedy
// action from the reward row. Every transfer yields exactly one result. Observe, act, the
// unused opcode and a learn with an action above four go from the input transfer straight
// to the done state, which loads the result register; the next item is taken only after
// that. A valid learn first issues six reads through the single read port of the table
// (five row entries and the entry to be replaced), then collects the last read, then
// multiplies, then writes the table entry and then loads the result register in the done
// state. A result that the receiver has not yet taken holds the block in the done state,
// so a stall lengthens the item. The input is not ready while an item is in progress. The
// table reads as zero after reset through per entry valid bits, so no clearing pass is
// needed. Configuration writes are taken at any time on their own channel but must only
// be issued while the block is idle.

`default_nettype none

module tabular_q_learning_agent
    import tqla_pkg::*;
#(
    parameter int Q_WIDTH = Q_WIDTH_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [OP_W-1:0]       opcode,
    input  wire logic [POS_W-1:0]      sensor_pos,
    input  wire logic [ACT_W-1:0]      action,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [STATE_W-1:0]    state_index,
    output logic      [ACT_W-1:0]      chosen_action,
    output logic      [OUT_Q_W-1:0]    new_q_value,
    output logic      [SUM_W-1:0]      table_sum,
    output logic                       converged,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PROD_W = Q_WIDTH + DISC_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [2:0] ScanLast = 3'(NUM_ACTIONS + 1);

    logic [DISC_W-1:0]  discount_reg;
    logic [POS_W-1:0]   edge_reg [NUM_BANDS];
    logic [LEARN_W-1:0] min_learn_reg;

    logic [2:0]         state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [ACT_W-1:0]   act_reg, act_next;
    logic [STATE_W-1:0] st_reg, st_next;
    logic [STATE_W-1:0] cs_reg, cs_next;
    logic [POS_W-1:0]   prev_pos_reg, prev_pos_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [Q_WIDTH-1:0] best_reg, best_next;
    logic [Q_WIDTH-1:0] old_reg, old_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [Q_WIDTH-1:0] newq_reg, newq_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   prev_sum_reg, prev_sum_next;
    logic [LEARN_W-1:0] learn_count_reg, learn_count_next;

    logic               out_valid_reg, out_valid_next;
    logic [STATE_W-1:0] out_state_reg, out_state_next;
    logic [ACT_W-1:0]   out_act_reg, out_act_next;
    logic [OUT_Q_W-1:0] out_q_reg, out_q_next;
    logic [SUM_W-1:0]   out_sum_reg, out_sum_next;
    logic               out_conv_reg, out_conv_next;

    logic [BAND_W-1:0]  band;
    logic [POS_W-1:0]   lower;
    logic [TREND_W-1:0] trend;
    logic [STATE_W-1:0] sample_state;

    qmem_port_t         wr_port;
    qmem_port_t         rd_port;
    logic [Q_WIDTH-1:0] rd_q;
    logic [Q_WIDTH:0]   sum_ext;
    logic [Q_WIDTH-1:0] newq_calc;

    tqla_qmem #(
        .Q_WIDTH(Q_WIDTH)
    ) u_qmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr_port),
        .wr_data (newq_calc),
        .rd      (rd_port),
        .rd_data (rd_q)
    );

    // The last band whose range holds the position wins; otherwise band zero.
    always_comb
    begin
        band  = '0;
        lower = '0;
        for (int k = 0; k < NUM_BANDS; k++)
        begin
            if (sensor_pos > lower && sensor_pos <= edge_reg[k])
            begin
                band = BAND_W'(k);
            end
            lower = edge_reg[k];
        end
        if (prev_pos_reg < sensor_pos)
        begin
            trend = 2'd0;
        end
        else if (prev_pos_reg == sensor_pos)
        begin
            trend = 2'd1;
        end
        else
        begin
            trend = 2'd2;
        end
        sample_state = STATE_W'({band, 1'b0}) + STATE_W'(band) + STATE_W'(trend);
    end

    always_comb
    begin
        sum_ext = {1'b0, prod_reg[PROD_W-1:DISC_W]}
                + (Q_WIDTH + 1)'(REWARD_ROM[cs_reg][act_reg]);
        newq_calc = sum_ext[Q_WIDTH] ? '1 : sum_ext[Q_WIDTH-1:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        act_next         = act_reg;
        st_next          = st_reg;
        cs_next          = cs_reg;
        prev_pos_next    = prev_pos_reg;
        cnt_next         = cnt_reg;
        best_next        = best_reg;
        old_next         = old_reg;
        prod_next        = prod_reg;
        newq_next        = newq_reg;
        sum_next         = sum_reg;
        prev_sum_next    = prev_sum_reg;
        learn_count_next = learn_count_reg;
        out_valid_next   = out_valid_reg;
        out_state_next   = out_state_reg;
        out_act_next     = out_act_reg;
        out_q_next       = out_q_reg;
        out_sum_next     = out_sum_reg;
        out_conv_next    = out_conv_reg;
        wr_port          = '0;
        rd_port          = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = opcode;
                    act_next  = action;
                    st_next   = sample_state;
                    newq_next = '0;
                    best_next = '0;
                    cnt_next  = '0;
                    if (opcode != OP_RESERVED)
                    begin
                        prev_pos_next = sensor_pos;
                    end
                    if (opcode == OP_OBSERVE)
                    begin
                        cs_next = sample_state;
                    end
                    if (opcode == OP_LEARN && action < ACT_W'(NUM_ACTIONS))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                // Reads go out one per cycle; each read's data is consumed in the next cycle.
                if (cnt_reg < ScanLast)
                begin
                    rd_port.en = 1'b1;
                    if (cnt_reg == ACT_W'(NUM_ACTIONS))
                    begin
                        rd_port.addr = q_addr(cs_reg, act_reg);
                    end
                    else
                    begin
                        rd_port.addr = q_addr(st_reg, cnt_reg);
                    end
                    cnt_next = cnt_reg + 3'd1;
                end
                if (cnt_reg == ScanLast)
                begin
                    old_next   = rd_q;
                    state_next = S_MUL;
                end
                else if (cnt_reg != '0 && rd_q > best_reg)
                begin
                    best_next = rd_q;
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(discount_reg) * PROD_W'(best_reg);
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                wr_port.en    = 1'b1;
                wr_port.addr  = q_addr(cs_reg, act_reg);
                newq_next     = newq_calc;
                prev_sum_next = sum_reg;
                sum_next      = sum_reg - SUM_W'(old_reg) + SUM_W'(newq_calc);
                if (learn_count_reg != '1)
                begin
                    learn_count_next = learn_count_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_state_next = st_reg;
                    out_act_next   = (op_reg == OP_ACT) ? act_greedy(st_reg) : '0;
                    out_q_next     = OUT_Q_W'(newq_reg);
                    out_sum_next   = sum_reg;
                    out_conv_next  = (learn_count_reg > min_learn_reg)
                                  && (sum_reg == prev_sum_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= '0;
            act_reg         <= '0;
            st_reg          <= '0;
            cs_reg          <= '0;
            prev_pos_reg    <= '0;
            cnt_reg         <= '0;
            best_reg        <= '0;
            old_reg         <= '0;
            prod_reg        <= '0;
            newq_reg        <= '0;
            sum_reg         <= '0;
            prev_sum_reg    <= '0;
            learn_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_state_reg   <= '0;
            out_act_reg     <= '0;
            out_q_reg       <= '0;
            out_sum_reg     <= '0;
            out_conv_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            act_reg         <= act_next;
            st_reg          <= st_next;
            cs_reg          <= cs_next;
            prev_pos_reg    <= prev_pos_next;
            cnt_reg         <= cnt_next;
            best_reg        <= best_next;
            old_reg         <= old_next;
            prod_reg        <= prod_next;
            newq_reg        <= newq_next;
            sum_reg         <= sum_next;
            prev_sum_reg    <= prev_sum_next;
            learn_count_reg <= learn_count_next;
            out_valid_reg   <= out_valid_next;
            out_state_reg   <= out_state_next;
            out_act_reg     <= out_act_next;
            out_q_reg       <= out_q_next;
            out_sum_reg     <= out_sum_next;
            out_conv_reg    <= out_conv_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discount_reg  <= DISCOUNT_RESET;
            min_learn_reg <= MIN_LEARN_STEPS_RESET;
            for (int k = 0; k < NUM_BANDS; k++)
            begin
                edge_reg[k] <= BAND_EDGE_RESET[k];
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DISCOUNT:        discount_reg  <= cfg_data[DISC_W-1:0];
                CFG_BAND_EDGE_ONE:   edge_reg[0]   <= cfg_data[POS_W-1:0];
                CFG_BAND_EDGE_TWO:   edge_reg[1]   <= cfg_data[POS_W-1:0];
                CFG_BAND_EDGE_THREE: edge_reg[2]   <= cfg_data[POS_W-1:0];
                CFG_BAND_EDGE_FOUR:  edge_reg[3]   <= cfg_data[POS_W-1:0];
                CFG_BAND_EDGE_FIVE:  edge_reg[4]   <= cfg_data[POS_W-1:0];
                CFG_MIN_LEARN_STEPS: min_learn_reg <= cfg_data[LEARN_W-1:0];
                default:             discount_reg  <= discount_reg;
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign state_index   = out_state_reg;
    assign chosen_action = out_act_reg;
    assign new_q_value   = out_q_reg;
    assign table_sum     = out_sum_reg;
    assign converged     = out_conv_reg;

    // The table is only written right after the multiply step.
    a_write_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        wr_port.en |-> ($past(state_reg) == S_MUL))
        else $error("table write outside the update sequence");

    a_sum_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WRITE) |=> (sum_reg == $past(sum_reg)))
        else $error("table sum changed without a table write");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && learn_count_reg != '1)
            |=> (learn_count_reg == $past(learn_count_reg) + 1'b1))
        else $error("learn count did not advance on a table write");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= ScanLast))
        else $error("scan counter ran past the last read");

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import tqla_pkg::*;

    localparam int          HALF_PERIOD    = 10;
    localparam int          RESET_CYCLES   = 12;
    localparam int          NUM_PHASES     = 8;
    localparam int          PHASE_ITEMS    = 150;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          REPORT_LIMIT   = 100;
    localparam int unsigned Q_LIMIT        = (1 << Q_WIDTH_DEFAULT) - 1;
    localparam int unsigned POS_MAX        = 9999;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [ACT_W-1:0] act;
    } sensor_sample_t;

    typedef struct packed {
        logic [STATE_W-1:0] state_index;
        logic [ACT_W-1:0]   chosen_action;
        logic [OUT_Q_W-1:0] new_q_value;
        logic [SUM_W-1:0]   table_sum;
        logic               converged;
    } agent_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       opcode        = OP_OBSERVE;
    logic [POS_W-1:0]      sensor_pos    = '0;
    logic [ACT_W-1:0]      action        = '0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic [STATE_W-1:0]    state_index;
    logic [ACT_W-1:0]      chosen_action;
    logic [OUT_Q_W-1:0]    new_q_value;
    logic [SUM_W-1:0]      table_sum;
    logic                  converged;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_DISCOUNT;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // Predictor copy of the agent state and its registers.
    logic [Q_WIDTH_DEFAULT-1:0] q_mem [TABLE_DEPTH];
    logic [POS_W-1:0]           last_seen_pos;
    logic [STATE_W-1:0]         held_state;
    logic [LEARN_W-1:0]         learn_total;
    logic [SUM_W-1:0]           sum_now;
    logic [SUM_W-1:0]           sum_before;
    logic [DISC_W-1:0]          discount_reg;
    logic [POS_W-1:0]           band_edge [NUM_BANDS];
    logic [LEARN_W-1:0]         min_steps_reg;

    sensor_sample_t pending_samples [$];
    agent_result_t  expected_results [$];
    sensor_sample_t next_sample;
    sensor_sample_t seen_sample;
    agent_result_t  want;
    agent_result_t  got;

    logic [POS_W-1:0] gen_edges [NUM_BANDS];
    logic [POS_W-1:0] last_pos = '0;
    logic             in_taken = 1'b0;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      hold_requests = 0;
    int unsigned      hold_seen = 0;
    int unsigned      hold_left = 0;
    int unsigned      idle_cycles = 0;
    int unsigned      mismatches = 0;
    int unsigned      op_count [4] = '{0, 0, 0, 0};
    int unsigned      converged_hits = 0;
    int unsigned      settings_used = 0;

    tabular_q_learning_agent dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .sensor_pos    (sensor_pos),
        .action        (action),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .state_index   (state_index),
        .chosen_action (chosen_action),
        .new_q_value   (new_q_value),
        .table_sum     (table_sum),
        .converged     (converged),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic agent_result_t predict_step(input sensor_sample_t s);
        agent_result_t r;
        int unsigned   band;
        int unsigned   lower;
        int unsigned   trend;
        int unsigned   st;
        int unsigned   cs;
        int unsigned   best;
        int unsigned   newq;
        int unsigned   old;
        int unsigned   pick;
        int unsigned   k;
        int unsigned   j;
        logic          wins;
        band  = 0;
        lower = 0;
        for (k = 0; k < NUM_BANDS; k++)
        begin
            if (s.pos > lower && s.pos <= band_edge[k])
            begin
                band = k;
            end
            lower = band_edge[k];
        end
        if (last_seen_pos < s.pos)
        begin
            trend = 0;
        end
        else if (last_seen_pos == s.pos)
        begin
            trend = 1;
        end
        else
        begin
            trend = 2;
        end
        st = band * 3 + trend;
        r.state_index   = STATE_W'(st);
        r.chosen_action = '0;
        r.new_q_value   = '0;
        if (s.op != OP_RESERVED)
        begin
            last_seen_pos = s.pos;
        end
        if (s.op == OP_OBSERVE)
        begin
            held_state = STATE_W'(st);
        end
        else if (s.op == OP_LEARN && s.act < NUM_ACTIONS)
        begin
            cs   = held_state % NUM_STATES;
            best = 0;
            for (j = 0; j < NUM_ACTIONS; j++)
            begin
                if (q_mem[st * NUM_ACTIONS + j] > best)
                begin
                    best = q_mem[st * NUM_ACTIONS + j];
                end
            end
            newq = REWARD_ROM[cs][s.act] + ((discount_reg * best) >> 8);
            if (newq > Q_LIMIT)
            begin
                newq = Q_LIMIT;
            end
            old = q_mem[cs * NUM_ACTIONS + s.act];
            q_mem[cs * NUM_ACTIONS + s.act] = newq[Q_WIDTH_DEFAULT-1:0];
            sum_before = sum_now;
            sum_now    = SUM_W'(sum_now - old + newq);
            if (learn_total != '1)
            begin
                learn_total = learn_total + 1'b1;
            end
            r.new_q_value = OUT_Q_W'(newq);
        end
        else if (s.op == OP_ACT)
        begin
            pick = NUM_ACTIONS - 1;
            for (k = NUM_ACTIONS - 1; k > 0; k--)
            begin
                wins = 1'b1;
                for (j = 0; j < NUM_ACTIONS; j++)
                begin
                    if (j != k - 1 && !(REWARD_ROM[st][k-1] > REWARD_ROM[st][j]))
                    begin
                        wins = 1'b0;
                    end
                end
                if (wins)
                begin
                    pick = k - 1;
                end
            end
            r.chosen_action = ACT_W'(NUM_ACTIONS - 1 - pick);
            if (r.chosen_action == '0 && st == STATE_EXCEPTION)
            begin
                r.chosen_action = ACT_W'(3);
            end
        end
        r.table_sum = sum_now;
        r.converged = (learn_total > min_steps_reg) && (sum_now == sum_before);
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int          e;
        logic [POS_W-1:0] p;
        case ($urandom_range(0, 9))
            0:
            begin
                p = last_pos;
            end
            1:
            begin
                p = ($urandom_range(0, 1) == 1) ? POS_W'(POS_MAX) : '0;
            end
            2, 3:
            begin
                e = int'(gen_edges[$urandom_range(0, NUM_BANDS - 1)]) +
                    int'($urandom_range(0, 2)) - 1;
                if (e < 0)
                begin
                    e = 0;
                end
                else if (e > int'(POS_MAX))
                begin
                    e = POS_MAX;
                end
                p = POS_W'(e);
            end
            default:
            begin
                p = POS_W'($urandom_range(0, POS_MAX));
            end
        endcase
        last_pos = p;
        return p;
    endfunction

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [ACT_W-1:0] act);
        sensor_sample_t s;
        s.op  = op;
        s.pos = pos;
        s.act = act;
        pending_samples.push_back(s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_DISCOUNT:        discount_reg  = val[DISC_W-1:0];
            CFG_BAND_EDGE_ONE:   band_edge[0]  = val[POS_W-1:0];
            CFG_BAND_EDGE_TWO:   band_edge[1]  = val[POS_W-1:0];
            CFG_BAND_EDGE_THREE: band_edge[2]  = val[POS_W-1:0];
            CFG_BAND_EDGE_FOUR:  band_edge[3]  = val[POS_W-1:0];
            CFG_BAND_EDGE_FIVE:  band_edge[4]  = val[POS_W-1:0];
            CFG_MIN_LEARN_STEPS: min_steps_reg = val[LEARN_W-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_sample = pending_samples.pop_front();
                in_valid      <= 1'b1;
                opcode        <= next_sample.op;
                sensor_pos    <= next_sample.pos;
                action        <= next_sample.act;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                seen_sample.op  = opcode;
                seen_sample.pos = sensor_pos;
                seen_sample.act = action;
                op_count[opcode]++;
                expected_results.push_back(predict_step(seen_sample));
            end
            if (out_valid && out_ready)
            begin
                got.state_index   = state_index;
                got.chosen_action = chosen_action;
                got.new_q_value   = new_q_value;
                got.table_sum     = table_sum;
                got.converged     = converged;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transfer with nothing expected, actual state %0d",
                             $time, state_index);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.converged)
                    begin
                        converged_hits++;
                    end
                    compare_field("state_index", 32'(want.state_index),
                                  32'(got.state_index));
                    compare_field("chosen_action", 32'(want.chosen_action),
                                  32'(got.chosen_action));
                    compare_field("new_q_value", 32'(want.new_q_value),
                                  32'(got.new_q_value));
                    compare_field("table_sum", 32'(want.table_sum), 32'(got.table_sum));
                    compare_field("converged", 32'(want.converged), 32'(got.converged));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int unsigned       p;
        int unsigned       n;
        int unsigned       k;
        logic [DISC_W-1:0] disc;
        logic [LEARN_W-1:0] steps;
        for (k = 0; k < TABLE_DEPTH; k++)
        begin
            q_mem[k] = '0;
        end
        last_seen_pos = '0;
        held_state    = '0;
        learn_total   = '0;
        sum_now       = '0;
        sum_before    = '0;
        discount_reg  = DISCOUNT_RESET;
        min_steps_reg = MIN_LEARN_STEPS_RESET;
        for (k = 0; k < NUM_BANDS; k++)
        begin
            band_edge[k] = BAND_EDGE_RESET[k];
            gen_edges[k] = BAND_EDGE_RESET[k];
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_item(OP_OBSERVE, 14'd0, 3'd0);
        queue_item(OP_OBSERVE, 14'd9999, 3'd7);
        queue_item(OP_OBSERVE, 14'd1500, 3'd0);
        queue_item(OP_LEARN, 14'd1501, 3'd4);
        queue_item(OP_LEARN, 14'd1501, 3'd0);
        queue_item(OP_OBSERVE, 14'd3000, 3'd0);
        queue_item(OP_LEARN, 14'd3500, 3'd3);
        queue_item(OP_LEARN, 14'd4000, 3'd2);
        queue_item(OP_OBSERVE, 14'd5000, 3'd1);
        queue_item(OP_LEARN, 14'd5500, 3'd1);
        queue_item(OP_LEARN, 14'd7000, 3'd5);
        queue_item(OP_LEARN, 14'd6000, 3'd7);
        queue_item(OP_RESERVED, 14'd8191, 3'd6);
        queue_item(OP_ACT, 14'd1000, 3'd0);
        queue_item(OP_ACT, 14'd2000, 3'd0);
        queue_item(OP_ACT, 14'd2000, 3'd0);
        queue_item(OP_ACT, 14'd1600, 3'd3);
        queue_item(OP_ACT, 14'd3200, 3'd0);
        queue_item(OP_ACT, 14'd4500, 3'd0);
        queue_item(OP_ACT, 14'd6000, 3'd0);
        queue_item(OP_ACT, 14'd8000, 3'd0);
        queue_item(OP_OBSERVE, 14'd5500, 3'd4);
        queue_item(OP_LEARN, 14'd5500, 3'd2);
        queue_item(OP_ACT, 14'd0, 3'd0);
        settings_used = 1;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    disc  = 8'd255;
                    steps = '0;
                    gen_edges = '{14'd1500, 14'd3000, 14'd4000, 14'd5500, 14'd7000};
                end
                1:
                begin
                    disc  = '0;
                    steps = '1;
                    gen_edges = '{14'd0, 14'd0, 14'd0, 14'd0, 14'd0};
                end
                2:
                begin
                    disc  = DISC_W'($urandom_range(0, 255));
                    steps = LEARN_W'($urandom_range(0, 700));
                    gen_edges = '{14'd0, 14'd9999, 14'd0, 14'd9999, 14'd0};
                end
                3:
                begin
                    disc  = DISC_W'($urandom_range(0, 255));
                    steps = LEARN_W'($urandom_range(0, 700));
                    gen_edges[0] = POS_W'($urandom_range(1, 2000));
                    for (k = 1; k < NUM_BANDS; k++)
                    begin
                        gen_edges[k] = gen_edges[k-1] + POS_W'($urandom_range(0, 1999));
                    end
                end
                default:
                begin
                    disc  = DISC_W'($urandom_range(0, 255));
                    steps = ($urandom_range(0, 3) == 0) ? '1 : LEARN_W'($urandom_range(0, 800));
                    for (k = 0; k < NUM_BANDS; k++)
                    begin
                        gen_edges[k] = POS_W'($urandom_range(0, POS_MAX));
                    end
                end
            endcase
            write_reg(CFG_DISCOUNT, CFG_DATA_W'(disc));
            write_reg(CFG_BAND_EDGE_ONE, CFG_DATA_W'(gen_edges[0]));
            write_reg(CFG_BAND_EDGE_TWO, CFG_DATA_W'(gen_edges[1]));
            write_reg(CFG_BAND_EDGE_THREE, CFG_DATA_W'(gen_edges[2]));
            write_reg(CFG_BAND_EDGE_FOUR, CFG_DATA_W'(gen_edges[3]));
            write_reg(CFG_BAND_EDGE_FIVE, CFG_DATA_W'(gen_edges[4]));
            write_reg(CFG_MIN_LEARN_STEPS, steps);
            settings_used++;
            @(posedge clk);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default:
                begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    queue_item(OP_OBSERVE, pick_position(), ACT_W'($urandom_range(0, 7)));
                    queue_item(OP_LEARN, pick_position(),
                               ACT_W'($urandom_range(0, NUM_ACTIONS - 1)));
                    n += 2;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        queue_item(OP_ACT, pick_position(), ACT_W'($urandom_range(0, 7)));
                        n++;
                    end
                end
                else
                begin
                    queue_item(OP_W'($urandom_range(0, 3)), pick_position(),
                               ACT_W'($urandom_range(0, 7)));
                    n++;
                end
            end
            if (p % 4 == 2)
            begin
                hold_requests++;
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Covered %0d observe, %0d learn, %0d act and %0d reserved transfers",
                 op_count[OP_OBSERVE], op_count[OP_LEARN], op_count[OP_ACT],
                 op_count[OP_RESERVED]);
        $display("over %0d register settings; %0d results flagged converged, final sum %0d.",
                 settings_used, converged_hits, sum_now);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
